@@ hdl/bwm_pkg.sv @@
package bwm_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BONE_MASK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_PITCH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_YAW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_ROLL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Z   = 3'd6;

   localparam logic [1:0] ROW_LAST = 2'd2;

   localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
   localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
   localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
   localparam logic signed [17:0] THREEQ_TURN  = 18'sd34560;
   localparam logic [17:0]        RAD_PER_UNIT = 18'd146409;
   localparam logic [31:0]        Q30_ONE      = 32'd1073741824;
   localparam logic signed [34:0] Q30_ONE_S    = 35'sd1073741824;
   localparam logic [18:0]        SIN_CAP      = 19'd65536;
   localparam logic [32:0]        SIN_ROUND    = 33'd8192;

   // reciprocals for the Horner divisions by 72, 42, 20 and 6, applied after
   // the factors of two are shifted out (odd parts 9, 21, 5 and 3)
   localparam logic [31:0] HORNER_MAG_0 = 32'd954437177;
   localparam logic [31:0] HORNER_MAG_1 = 32'd1636178018;
   localparam logic [31:0] HORNER_MAG_2 = 32'd1717986919;
   localparam logic [31:0] HORNER_MAG_3 = 32'd2863311531;
   localparam logic [1:0]  HORNER_LAST  = 2'd3;
   localparam logic [2:0]  SINE_LAST    = 3'd5;
   localparam logic [3:0]  PROD_LAST    = 4'd11;

   typedef struct packed {
      logic [6:0]         bone_index;
      logic signed [7:0]  parent_index;
      logic [31:0]        bone_flags;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               is_last_bone;
   } req_payload_type;

   typedef struct packed {
      logic [6:0]         out_bone;
      logic [1:0]         row;
      logic signed [31:0] col_0;
      logic signed [31:0] col_1;
      logic signed [31:0] col_2;
      logic signed [31:0] col_3;
      logic               last_row;
      logic               skeleton_done;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [16:0] pitch;
      logic signed [16:0] yaw;
      logic signed [16:0] roll;
   } root_angles_type;

   typedef logic [8:0][31:0] root_rot_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QMUL,
      S_LOC,
      S_MUL,
      S_SUM
   } bwm_state_type;

   typedef enum logic [3:0] {
      R_IDLE,
      R_RED,
      R_X,
      R_X2,
      R_DIV,
      R_DIVEND,
      R_TMUL,
      R_SMUL,
      R_SEND,
      R_PMUL,
      R_PACC
   } root_state_type;

   function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = 48'(p >>> 16);
      if (s > 48'sd2147483647) return 32'sh7FFF_FFFF;
      if (s < -48'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sum(input logic signed [34:0] s);
      if (s > 35'sd2147483647) return 32'sh7FFF_FFFF;
      if (s < -35'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
   endfunction

endpackage

@@ hdl/bwm_ram.sv @@
module bwm_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/bwm_root.sv @@
module bwm_root (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bwm_pkg::root_angles_type angles,
   output logic                     busy,
   output bwm_pkg::root_rot_type    rot
);
   import bwm_pkg::*;

   localparam int SP = 0;
   localparam int CP = 1;
   localparam int SY = 2;
   localparam int CY = 3;
   localparam int SR = 4;
   localparam int CR = 5;
   localparam int CRCY = 0;
   localparam int CRSY = 1;
   localparam int SRCY = 2;
   localparam int SRSY = 3;

   root_state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] h_ff, h_in;
   logic [3:0] step_ff, step_in;

   logic [63:0]        mul_ff;
   logic [31:0]        x_ff;
   logic [31:0]        x2_ff;
   logic [30:0]        t_ff;
   logic [31:0]        dq_ff;
   logic [1:0]         quad_ff;
   logic signed [17:0] sin_ff [6];
   logic signed [17:0] v_ff [4];
   logic signed [35:0] pmul_ff;
   root_rot_type       rot_ff;

   logic signed [17:0] ang, m1, m2, m3, base;
   logic [1:0]         quad;
   logic [13:0]        r_raw, r_fold;
   logic [31:0]        dv_num, dv_mag, dv_quo;
   logic [31:0]        s_q30;
   logic [32:0]        s_rnd;
   logic [18:0]        s_sh, s_cap;
   logic signed [17:0] sin_pos, sin_val;
   logic signed [17:0] opa, opb;
   logic signed [19:0] p;

   // angle reduction into a quadrant offset
   always_comb begin
      case (k_ff[2:1])
         2'd0:    ang = 18'(angles.pitch);
         2'd1:    ang = 18'(angles.yaw);
         default: ang = 18'(angles.roll);
      endcase
      if (k_ff[0]) begin
         ang = ang + QUARTER_TURN;
      end
      m1 = (ang < 0) ? ang + FULL_TURN : ang;
      m2 = (m1 < 0) ? m1 + FULL_TURN : m1;
      m3 = (m2 >= FULL_TURN) ? m2 - FULL_TURN : m2;
      if (m3 >= THREEQ_TURN) begin
         quad = 2'd3;
         base = THREEQ_TURN;
      end else if (m3 >= HALF_TURN) begin
         quad = 2'd2;
         base = HALF_TURN;
      end else if (m3 >= QUARTER_TURN) begin
         quad = 2'd1;
         base = QUARTER_TURN;
      end else begin
         quad = 2'd0;
         base = '0;
      end
      r_raw  = 14'(m3 - base);
      r_fold = quad[0] ? 14'(QUARTER_TURN) - r_raw : r_raw;
   end

   // constant division: shift out the factor of two, multiply by the reciprocal
   always_comb begin
      case (h_ff)
         2'd0: begin
            dv_num = {3'd0, dq_ff[31:3]};
            dv_mag = HORNER_MAG_0;
         end
         2'd1: begin
            dv_num = {1'd0, dq_ff[31:1]};
            dv_mag = HORNER_MAG_1;
         end
         2'd2: begin
            dv_num = {2'd0, dq_ff[31:2]};
            dv_mag = HORNER_MAG_2;
         end
         default: begin
            dv_num = {1'd0, dq_ff[31:1]};
            dv_mag = HORNER_MAG_3;
         end
      endcase
      dv_quo = (h_ff == 2'd1) ? 32'(mul_ff[63:35]) : 32'(mul_ff[63:33]);
   end

   always_comb begin
      s_q30   = mul_ff[61:30];
      s_rnd   = 33'(s_q30) + SIN_ROUND;
      s_sh    = s_rnd[32:14];
      s_cap   = (s_sh > SIN_CAP) ? SIN_CAP : s_sh;
      sin_pos = $signed({1'b0, s_cap[16:0]});
      sin_val = quad_ff[1] ? -sin_pos : sin_pos;
   end

   always_comb begin
      case (step_ff)
         4'd0:    begin opa = sin_ff[CR]; opb = sin_ff[CY]; end
         4'd1:    begin opa = sin_ff[CR]; opb = sin_ff[SY]; end
         4'd2:    begin opa = sin_ff[SR]; opb = sin_ff[CY]; end
         4'd3:    begin opa = sin_ff[SR]; opb = sin_ff[SY]; end
         4'd4:    begin opa = sin_ff[CP]; opb = sin_ff[CY]; end
         4'd5:    begin opa = sin_ff[SP]; opb = v_ff[SRCY]; end
         4'd6:    begin opa = sin_ff[SP]; opb = v_ff[CRCY]; end
         4'd7:    begin opa = sin_ff[CP]; opb = sin_ff[SY]; end
         4'd8:    begin opa = sin_ff[SP]; opb = v_ff[SRSY]; end
         4'd9:    begin opa = sin_ff[SP]; opb = v_ff[CRSY]; end
         4'd10:   begin opa = sin_ff[SR]; opb = sin_ff[CP]; end
         default: begin opa = sin_ff[CR]; opb = sin_ff[CP]; end
      endcase
      p = 20'(pmul_ff >>> 16);
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      h_in     = h_ff;
      step_in  = step_ff;
      if (start) begin
         state_in = R_RED;
         k_in     = '0;
      end else begin
         case (state_ff)
            R_IDLE: ;
            R_RED:  state_in = R_X;
            R_X: begin
               state_in = R_X2;
               h_in     = '0;
            end
            R_X2:   state_in = R_DIV;
            R_DIV:  state_in = R_DIVEND;
            R_DIVEND: begin
               if (h_ff == HORNER_LAST) begin
                  state_in = R_SMUL;
               end else begin
                  h_in     = h_ff + 2'd1;
                  state_in = R_TMUL;
               end
            end
            R_TMUL: state_in = R_X2;
            R_SMUL: state_in = R_SEND;
            R_SEND: begin
               if (k_ff == SINE_LAST) begin
                  state_in = R_PMUL;
                  step_in  = '0;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = R_RED;
               end
            end
            R_PMUL: state_in = R_PACC;
            R_PACC: begin
               if (step_ff == PROD_LAST) begin
                  state_in = R_IDLE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = R_PMUL;
               end
            end
            default: state_in = R_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_RED;
         k_ff     <= '0;
         h_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         h_ff     <= h_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         R_RED: begin
            mul_ff  <= r_fold * RAD_PER_UNIT;
            quad_ff <= quad;
         end
         R_X: begin
            x_ff   <= mul_ff[31:0];
            mul_ff <= mul_ff[31:0] * mul_ff[31:0];
         end
         R_X2: begin
            if (h_ff == 2'd0) begin
               x2_ff <= mul_ff[61:30];
            end
            dq_ff <= mul_ff[61:30];
         end
         R_DIV:    mul_ff <= dv_num * dv_mag;
         R_DIVEND: t_ff   <= 31'(Q30_ONE - dv_quo);
         R_TMUL:   mul_ff <= x2_ff * t_ff;
         R_SMUL:   mul_ff <= x_ff * t_ff;
         R_SEND:   sin_ff[k_ff] <= sin_val;
         R_PMUL:   pmul_ff <= opa * opb;
         R_PACC: begin
            case (step_ff)
               4'd0:    v_ff[CRCY] <= p[17:0];
               4'd1:    v_ff[CRSY] <= p[17:0];
               4'd2:    v_ff[SRCY] <= p[17:0];
               4'd3:    v_ff[SRSY] <= p[17:0];
               4'd4:    rot_ff[0] <= 32'(p);
               4'd5:    rot_ff[1] <= 32'(21'(p) - 21'(v_ff[CRSY]));
               4'd6:    rot_ff[2] <= 32'(21'(p) + 21'(v_ff[SRSY]));
               4'd7:    rot_ff[3] <= 32'(p);
               4'd8:    rot_ff[4] <= 32'(21'(p) + 21'(v_ff[CRCY]));
               4'd9:    rot_ff[5] <= 32'(21'(p) - 21'(v_ff[SRCY]));
               4'd10:   rot_ff[7] <= 32'(p);
               default: begin
                  rot_ff[8] <= 32'(p);
                  rot_ff[6] <= -(32'(sin_ff[SP]));
               end
            endcase
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != R_IDLE);
   assign rot  = rot_ff;

endmodule

@@ hdl/bone_world_matrix_builder.sv @@
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_payload_type, one bone
// rsp      out        rsp_valid/rsp_ready  rsp_payload_type, one matrix row
// csr      in         csr_we               csr_index, csr_wdata
//
// A computed bone passes through quaternion products and the local matrix, then a multiply
// and a sum state per row on the row-wide matrix store port. Masked-out and out-of-range
// bones are accepted and dropped with no result. Reset and every register write rebuild the
// root matrix (shared sine and reciprocal-multiply unit); no item is accepted meanwhile.
// The store needs no clearing pass: per-bone valid flags read unwritten slots as zero.
// A stalled rsp holds the row in flight.
module bone_world_matrix_builder #(
   parameter int MAX_BONES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bwm_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bwm_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_we,
   input  logic [bwm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [31:0]                           csr_wdata
);
   import bwm_pkg::*;

   localparam int SLOT_W = (MAX_BONES > 2) ? $clog2(MAX_BONES) : 1;
   localparam int ROWS   = 3 * MAX_BONES;
   localparam int AW     = $clog2(ROWS);

   localparam int QXX = 0;
   localparam int QYY = 1;
   localparam int QZZ = 2;
   localparam int QXY = 3;
   localparam int QXZ = 4;
   localparam int QYZ = 5;
   localparam int QWX = 6;
   localparam int QWY = 7;
   localparam int QWZ = 8;

   function automatic logic signed [31:0] q30_to_q16(input logic signed [34:0] e);
      return 32'(e >>> 14);
   endfunction

   function automatic logic signed [34:0] dbl(input logic signed [31:0] v);
      return 35'(v) <<< 1;
   endfunction

   logic [31:0]        mask_ff;
   root_angles_type    angles_ff;
   logic signed [31:0] origin_ff [3];
   logic               cfg_hit;

   bwm_state_type      state_ff, state_in;
   logic [1:0]         row_ff;
   logic [MAX_BONES-1:0] valid_ff;
   req_payload_type    item_ff;
   logic signed [31:0] qp_ff [9];
   logic signed [31:0] loc_ff [12];
   logic signed [63:0] prod_ff [12];
   logic signed [31:0] a3_ff;
   rsp_payload_type    rsp_ff;
   logic               rsp_valid_ff;

   logic               root_busy;
   root_rot_type       root_rot;

   logic               go, out_free, par_root, par_valid;
   logic [SLOT_W-1:0]  par_slot, bone_slot;
   logic [1:0]         rd_row;
   logic               ram_re, ram_we, load_out;
   logic [AW-1:0]      ram_raddr, ram_waddr;
   logic [127:0]       ram_rdata, ram_wdata;
   logic signed [31:0] a_op [4];
   logic signed [31:0] res [4];

   always_comb begin
      case (csr_index)
         CSR_BONE_MASK, CSR_ROOT_PITCH, CSR_ROOT_YAW, CSR_ROOT_ROLL,
         CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_ORIGIN_Z: cfg_hit = csr_we;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         angles_ff    <= '0;
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BONE_MASK:  mask_ff         <= csr_wdata;
            CSR_ROOT_PITCH: angles_ff.pitch <= csr_wdata[16:0];
            CSR_ROOT_YAW:   angles_ff.yaw   <= csr_wdata[16:0];
            CSR_ROOT_ROLL:  angles_ff.roll  <= csr_wdata[16:0];
            CSR_ORIGIN_X:   origin_ff[0]    <= csr_wdata;
            CSR_ORIGIN_Y:   origin_ff[1]    <= csr_wdata;
            CSR_ORIGIN_Z:   origin_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   bwm_root u_root (
      .clock  (clock),
      .reset  (reset),
      .start  (cfg_hit),
      .angles (angles_ff),
      .busy   (root_busy),
      .rot    (root_rot)
   );

   bwm_ram #(
      .WIDTH (128),
      .DEPTH (ROWS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign go        = (int'(req_data.bone_index) < MAX_BONES) &&
                      ((req_data.bone_flags & mask_ff) != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign par_root  = item_ff.parent_index[7] ||
                      (int'(item_ff.parent_index[6:0]) >= MAX_BONES);
   assign par_slot  = SLOT_W'(item_ff.parent_index[6:0]);
   assign bone_slot = SLOT_W'(item_ff.bone_index);
   assign par_valid = valid_ff[par_slot];
   assign ram_raddr = (AW'(par_slot) << 1) + AW'(par_slot) + AW'(rd_row);
   assign ram_waddr = (AW'(bone_slot) << 1) + AW'(bone_slot) + AW'(row_ff);
   assign ram_wdata = {res[3], res[2], res[1], res[0]};

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ram_re    = 1'b0;
      rd_row    = row_ff;
      ram_we    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !root_busy;
            if (req_valid && !root_busy && go) begin
               state_in = S_QMUL;
            end
         end
         S_QMUL: state_in = S_LOC;
         S_LOC: begin
            ram_re   = 1'b1;
            rd_row   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // next parent row lands while this one is summed
            ram_re   = (row_ff != ROW_LAST);
            rd_row   = row_ff + 2'd1;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (out_free) begin
               ram_we   = 1'b1;
               load_out = 1'b1;
               state_in = (row_ff == ROW_LAST) ? S_IDLE : S_MUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      case (row_ff)
         2'd0: begin
            a_op[0] = $signed(root_rot[0]);
            a_op[1] = $signed(root_rot[1]);
            a_op[2] = $signed(root_rot[2]);
         end
         2'd1: begin
            a_op[0] = $signed(root_rot[3]);
            a_op[1] = $signed(root_rot[4]);
            a_op[2] = $signed(root_rot[5]);
         end
         default: begin
            a_op[0] = $signed(root_rot[6]);
            a_op[1] = $signed(root_rot[7]);
            a_op[2] = $signed(root_rot[8]);
         end
      endcase
      a_op[3] = origin_ff[row_ff];
      if (!par_root) begin
         for (int j = 0; j < 4; j++) begin
            a_op[j] = par_valid ? $signed(ram_rdata[32*j +: 32]) : '0;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         res[j] = sat_sum(35'(sat_prod(prod_ff[j])) + 35'(sat_prod(prod_ff[3+j])) +
                          35'(sat_prod(prod_ff[6+j])));
      end
      res[3] = sat_sum(35'(sat_prod(prod_ff[9])) + 35'(sat_prod(prod_ff[10])) +
                       35'(sat_prod(prod_ff[11])) + 35'(a3_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_LOC) begin
            row_ff <= '0;
         end else if (load_out) begin
            row_ff <= row_ff + 2'd1;
         end
         if (load_out && row_ff == ROW_LAST) begin
            valid_ff[bone_slot] <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (state_ff == S_QMUL) begin
         qp_ff[QXX] <= $signed(item_ff.quat_x) * $signed(item_ff.quat_x);
         qp_ff[QYY] <= $signed(item_ff.quat_y) * $signed(item_ff.quat_y);
         qp_ff[QZZ] <= $signed(item_ff.quat_z) * $signed(item_ff.quat_z);
         qp_ff[QXY] <= $signed(item_ff.quat_x) * $signed(item_ff.quat_y);
         qp_ff[QXZ] <= $signed(item_ff.quat_x) * $signed(item_ff.quat_z);
         qp_ff[QYZ] <= $signed(item_ff.quat_y) * $signed(item_ff.quat_z);
         qp_ff[QWX] <= $signed(item_ff.quat_w) * $signed(item_ff.quat_x);
         qp_ff[QWY] <= $signed(item_ff.quat_w) * $signed(item_ff.quat_y);
         qp_ff[QWZ] <= $signed(item_ff.quat_w) * $signed(item_ff.quat_z);
      end
      if (state_ff == S_LOC) begin
         loc_ff[0]  <= q30_to_q16(Q30_ONE_S - dbl(qp_ff[QYY]) - dbl(qp_ff[QZZ]));
         loc_ff[1]  <= q30_to_q16(dbl(qp_ff[QXY]) - dbl(qp_ff[QWZ]));
         loc_ff[2]  <= q30_to_q16(dbl(qp_ff[QXZ]) + dbl(qp_ff[QWY]));
         loc_ff[3]  <= item_ff.pos_x;
         loc_ff[4]  <= q30_to_q16(dbl(qp_ff[QXY]) + dbl(qp_ff[QWZ]));
         loc_ff[5]  <= q30_to_q16(Q30_ONE_S - dbl(qp_ff[QXX]) - dbl(qp_ff[QZZ]));
         loc_ff[6]  <= q30_to_q16(dbl(qp_ff[QYZ]) - dbl(qp_ff[QWX]));
         loc_ff[7]  <= item_ff.pos_y;
         loc_ff[8]  <= q30_to_q16(dbl(qp_ff[QXZ]) - dbl(qp_ff[QWY]));
         loc_ff[9]  <= q30_to_q16(dbl(qp_ff[QYZ]) + dbl(qp_ff[QWX]));
         loc_ff[10] <= q30_to_q16(Q30_ONE_S - dbl(qp_ff[QXX]) - dbl(qp_ff[QYY]));
         loc_ff[11] <= item_ff.pos_z;
      end
      if (state_ff == S_MUL) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[j]   <= a_op[0] * loc_ff[j];
            prod_ff[3+j] <= a_op[1] * loc_ff[4+j];
            prod_ff[6+j] <= a_op[2] * loc_ff[8+j];
         end
         prod_ff[9]  <= loc_ff[3] * a_op[0];
         prod_ff[10] <= loc_ff[7] * a_op[1];
         prod_ff[11] <= loc_ff[11] * a_op[2];
         a3_ff       <= a_op[3];
      end
      if (load_out) begin
         rsp_ff.out_bone      <= item_ff.bone_index;
         rsp_ff.row           <= row_ff;
         rsp_ff.col_0         <= res[0];
         rsp_ff.col_1         <= res[1];
         rsp_ff.col_2         <= res[2];
         rsp_ff.col_3         <= res[3];
         rsp_ff.last_row      <= (row_ff == ROW_LAST);
         rsp_ff.skeleton_done <= (row_ff == ROW_LAST) && item_ff.is_last_bone;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_store_write_shown: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_valid)
      else $error("store row written without a result row");
   a_done_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.skeleton_done) |-> rsp_data.last_row)
      else $error("skeleton done away from the last row");
   a_third_row_ends: assert property (@(posedge clock) disable iff (reset)
      (ram_we && row_ff == ROW_LAST) |=> (state_ff == S_IDLE))
      else $error("bone not finished after its third row");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import bwm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 24;
   localparam int ANGLE_MAX = 46080;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   bone_world_matrix_builder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // shadow state
   logic [31:0] mask_sh;
   int pitch_sh, yaw_sh, roll_sh;
   int org_x, org_y, org_z;
   int world_mat [128][12];
   int root_mat [12];

   req_payload_type bone_q[$];
   rsp_payload_type rows_expected[$];
   int send_idle, recv_idle;
   int errors;
   int quiet_cycles;
   bit req_took;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic int fx_mul(int a, int b);
      return sat32((longint'(a) * longint'(b)) >>> 16);
   endfunction

   function automatic int sine_q16(int a);
      int m, quad, r;
      longint unsigned x, x2, t, s;
      m = a % ANGLE_MAX;
      if (m < 0) m += ANGLE_MAX;
      quad = m / int'(QUARTER_TURN);
      r = m % int'(QUARTER_TURN);
      if (quad & 1) r = int'(QUARTER_TURN) - r;
      x = longint'(r) * 146409;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      s = (s + (64'd1 << 13)) >> 14;
      if (s > 65536) s = 65536;
      return (quad >= 2) ? -int'(s) : int'(s);
   endfunction

   function automatic void rebuild_root();
      int sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
      sp = sine_q16(pitch_sh);
      cp = sine_q16(pitch_sh + int'(QUARTER_TURN));
      sy = sine_q16(yaw_sh);
      cy = sine_q16(yaw_sh + int'(QUARTER_TURN));
      sr = sine_q16(roll_sh);
      cr = sine_q16(roll_sh + int'(QUARTER_TURN));
      crcy = fx_mul(cr, cy);
      crsy = fx_mul(cr, sy);
      srcy = fx_mul(sr, cy);
      srsy = fx_mul(sr, sy);
      root_mat[0] = fx_mul(cp, cy);
      root_mat[1] = sat32(longint'(fx_mul(sp, srcy)) - crsy);
      root_mat[2] = sat32(longint'(fx_mul(sp, crcy)) + srsy);
      root_mat[3] = org_x;
      root_mat[4] = fx_mul(cp, sy);
      root_mat[5] = sat32(longint'(fx_mul(sp, srsy)) + crcy);
      root_mat[6] = sat32(longint'(fx_mul(sp, crsy)) - srcy);
      root_mat[7] = org_y;
      root_mat[8] = sat32(-longint'(sp));
      root_mat[9] = fx_mul(sr, cp);
      root_mat[10] = fx_mul(cr, cp);
      root_mat[11] = org_z;
   endfunction

   function automatic int q30_to_q16(longint v);
      return sat32(v >>> 14);
   endfunction

   function automatic void predict_bone_rows(req_payload_type b);
      longint qx, qy, qz, qw, one;
      int loc [12];
      int pm [12];
      int res [12];
      rsp_payload_type r;
      if ((b.bone_flags & mask_sh) == 32'd0) return;
      qx = b.quat_x;
      qy = b.quat_y;
      qz = b.quat_z;
      qw = b.quat_w;
      one = 64'sd1 << 30;
      loc[0] = q30_to_q16(one - 2 * qy * qy - 2 * qz * qz);
      loc[1] = q30_to_q16(2 * qx * qy - 2 * qw * qz);
      loc[2] = q30_to_q16(2 * qx * qz + 2 * qw * qy);
      loc[3] = b.pos_x;
      loc[4] = q30_to_q16(2 * qx * qy + 2 * qw * qz);
      loc[5] = q30_to_q16(one - 2 * qx * qx - 2 * qz * qz);
      loc[6] = q30_to_q16(2 * qy * qz - 2 * qw * qx);
      loc[7] = b.pos_y;
      loc[8] = q30_to_q16(2 * qx * qz - 2 * qw * qy);
      loc[9] = q30_to_q16(2 * qy * qz + 2 * qw * qx);
      loc[10] = q30_to_q16(one - 2 * qx * qx - 2 * qy * qy);
      loc[11] = b.pos_z;
      for (int k = 0; k < 12; k++)
         pm[k] = (b.parent_index < 0) ? root_mat[k] : world_mat[b.parent_index][k];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            res[4*i+j] = sat32(longint'(fx_mul(pm[4*i], loc[j]))
                               + fx_mul(pm[4*i+1], loc[4+j])
                               + fx_mul(pm[4*i+2], loc[8+j]));
         res[4*i+3] = sat32(longint'(fx_mul(loc[3], pm[4*i]))
                            + fx_mul(loc[7], pm[4*i+1])
                            + fx_mul(loc[11], pm[4*i+2]) + pm[4*i+3]);
      end
      for (int k = 0; k < 12; k++) world_mat[b.bone_index][k] = res[k];
      for (int i = 0; i < 3; i++) begin
         r.out_bone = b.bone_index;
         r.row = 2'(i);
         r.col_0 = res[4*i];
         r.col_1 = res[4*i+1];
         r.col_2 = res[4*i+2];
         r.col_3 = res[4*i+3];
         r.last_row = (2'(i) == ROW_LAST);
         r.skeleton_done = (2'(i) == ROW_LAST) && b.is_last_bone;
         rows_expected.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, longint e, longint a);
      if (e != a) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
         errors++;
      end
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_payload_type e;
      req_took = req_valid && req_ready;
      if (req_took) predict_bone_rows(req_data);
      if (rsp_valid && rsp_ready) begin
         if (rows_expected.size() == 0) begin
            $display("%0t unexpected row bone %0d row %0d", $time, rsp_data.out_bone,
                     rsp_data.row);
            errors++;
         end else begin
            e = rows_expected.pop_front();
            check_field("out_bone", e.out_bone, rsp_data.out_bone);
            check_field("row", e.row, rsp_data.row);
            check_field("col_0", e.col_0, rsp_data.col_0);
            check_field("col_1", e.col_1, rsp_data.col_1);
            check_field("col_2", e.col_2, rsp_data.col_2);
            check_field("col_3", e.col_3, rsp_data.col_3);
            check_field("last_row", e.last_row, rsp_data.last_row);
            check_field("skeleton_done", e.skeleton_done, rsp_data.skeleton_done);
         end
      end
      if (req_took || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bone_world_matrix_builder verification failed");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_took) begin
            if (bone_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_data <= bone_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   function automatic req_payload_type make_bone(int bone, int parent, logic [31:0] flags,
                                                 int qx, int qy, int qz, int qw,
                                                 int px, int py, int pz, bit last);
      req_payload_type b;
      b.bone_index = 7'(bone);
      b.parent_index = 8'(parent);
      b.bone_flags = flags;
      b.quat_x = 16'(qx);
      b.quat_y = 16'(qy);
      b.quat_z = 16'(qz);
      b.quat_w = 16'(qw);
      b.pos_x = px;
      b.pos_y = py;
      b.pos_z = pz;
      b.is_last_bone = last;
      return b;
   endfunction

   function automatic int rand_pos();
      if ($urandom_range(0, 1)) return int'($urandom());
      return int'($urandom_range(0, 2 * 655360)) - 655360;
   endfunction

   // one skeleton in index order, with a little noise
   function automatic int push_skeleton();
      int n, base, parent;
      logic [31:0] flags;
      n = $urandom_range(3, 30);
      base = $urandom_range(0, 128 - n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0, 1: parent = -1;
            2: parent = int'($urandom_range(0, 255)) - 128;
            default: parent = (i == 0) ? -1 : base + int'($urandom_range(0, i - 1));
         endcase
         flags = ($urandom_range(0, 9) == 0) ? $urandom() & $urandom() : $urandom();
         bone_q.push_back(make_bone(base + i, parent, flags,
            int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
            rand_pos(), rand_pos(), rand_pos(), i == n - 1));
      end
      return n;
   endfunction

   task automatic drain();
      while (bone_q.size() != 0 || req_valid || rows_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BONE_MASK:  mask_sh = val;
         CSR_ROOT_PITCH: pitch_sh = int'($signed(val[16:0]));
         CSR_ROOT_YAW:   yaw_sh = int'($signed(val[16:0]));
         CSR_ROOT_ROLL:  roll_sh = int'($signed(val[16:0]));
         CSR_ORIGIN_X:   org_x = int'(val);
         CSR_ORIGIN_Y:   org_y = int'(val);
         CSR_ORIGIN_Z:   org_z = int'(val);
         default: return;
      endcase
      rebuild_root();
   endtask

   function automatic int rand_angle();
      return int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
   endfunction

   initial begin
      int total, phase, pa, ya, ra;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_BONE_MASK;
      csr_wdata = '0;
      errors = 0;
      quiet_cycles = 0;
      req_took = 1'b0;
      send_idle = 9;
      recv_idle = 58;
      mask_sh = 32'hFFFF_FFFF;
      pitch_sh = 0;
      yaw_sh = 0;
      roll_sh = 0;
      org_x = 0;
      org_y = 0;
      org_z = 0;
      foreach (world_mat[i, j]) world_mat[i][j] = 0;
      rebuild_root();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      bone_q.push_back(make_bone(0, -1, 1, 0, 0, 0, 32767, 0, 0, 0, 0));
      bone_q.push_back(make_bone(1, 0, 2, 32767, 0, 0, 0, 32'sh7FFF_FFFF,
                                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
      bone_q.push_back(make_bone(2, 1, 4, -32768, -32768, -32768, -32768,
                                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0));
      bone_q.push_back(make_bone(3, 2, 8, 32767, 32767, 32767, 32767,
                                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
      bone_q.push_back(make_bone(4, 4, 16, 1000, -2000, 3000, 30000, 65536, -65536, 7, 0));
      bone_q.push_back(make_bone(5, 100, 32, 0, 0, 0, 32767, 65536, 0, 0, 0));
      bone_q.push_back(make_bone(6, -128, 64, -32768, 32767, -32768, 32767, 1, -1, 2, 0));
      bone_q.push_back(make_bone(7, 127, 128, 12345, -23456, 4321, 9999, 0, 0, 0, 0));
      bone_q.push_back(make_bone(8, 0, 0, 5, 5, 5, 5, 5, 5, 5, 1));
      bone_q.push_back(make_bone(3, 3, 32'hFFFF_FFFF, 0, 23170, 0, 23170, 655360, 0, 0, 0));
      bone_q.push_back(make_bone(9, 3, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0));
      bone_q.push_back(make_bone(127, 9, 32'h0001_0000, 32767, -32768, 0, 1,
                                 -65536, 65536, 32'sh7FFF_FFFF, 1));
      drain();
      csr_write(CSR_BONE_MASK, 32'd0);
      bone_q.push_back(make_bone(10, -1, 32'hFFFF_FFFF, 0, 0, 0, 32767, 0, 0, 0, 1));
      bone_q.push_back(make_bone(11, 10, 32'h5555_5555, 100, 100, 100, 100, 1, 1, 1, 0));
      drain();
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);

      total = 0;
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle = 58;
            recv_idle = 9;
         end else if (phase == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         drain();
         case (phase)
            0: begin
               pa = ANGLE_MAX;
               ya = ANGLE_MAX;
               ra = ANGLE_MAX;
            end
            1: begin
               pa = -ANGLE_MAX;
               ya = -ANGLE_MAX;
               ra = -ANGLE_MAX;
            end
            default: begin
               pa = rand_angle();
               ya = rand_angle();
               ra = rand_angle();
            end
         endcase
         csr_write(CSR_BONE_MASK, (phase == 0) ? 32'hFFFF_FFFF :
                   (phase == 1) ? 32'h0000_FFFF : $urandom() | $urandom());
         csr_write(CSR_ROOT_PITCH, 32'(pa));
         csr_write(CSR_ROOT_YAW, 32'(ya));
         csr_write(CSR_ROOT_ROLL, 32'(ra));
         csr_write(CSR_ORIGIN_X, (phase == 0) ? 32'h7FFF_FFFF :
                   (phase == 1) ? 32'h8000_0000 : $urandom());
         csr_write(CSR_ORIGIN_Y, (phase == 1) ? 32'h7FFF_FFFF :
                   (phase == 0) ? 32'h8000_0000 : $urandom());
         csr_write(CSR_ORIGIN_Z, (phase < 2) ? 32'h0 : $urandom());
         while (total < (phase + 1) * 54) total += push_skeleton();
      end
      drain();
      errors += rows_expected.size();
      if (errors == 0) begin
         $display("bone_world_matrix_builder verification clean");
      end else begin
         $display("bone_world_matrix_builder verification failed");
      end
      $finish;
   end
endmodule
